>>> src/trbp_pkg.sv
`timescale 1ns / 1ps

package trbp_pkg;

  // Header and per-sample flag groups of the box flags field
  localparam logic [15:0] HdrMask = 16'h00FF;
  localparam logic [15:0] RecMask = 16'hFF00;

  // Result kinds
  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_EMPTY  = 1'b1
  } kind_e;

  // One input word as it travels through the input register
  typedef struct packed {
    logic [31:0] stream_word;
    logic        box_start;
  } in_item_t;

  // One result record
  typedef struct packed {
    kind_e       result_kind;
    logic [31:0] sample_index;
    logic [31:0] sample_dur;
    logic [31:0] sample_bytes;
    logic [31:0] sample_flag_word;
    logic [31:0] composition_offset;
    logic [31:0] data_ofs_value;
    logic [31:0] first_flags_value;
    logic        last_of_run;
  } result_t;

endpackage

>>> src/track_run_box_parser_top.sv
`timescale 1ns / 1ps

// Track fragment run box parser.
// Input channel: one 32-bit box payload word per request on stream_word_i,
// with box_start_i marking the version/flags word that opens a box. The
// sample count follows, then the header words named by flag bits 0-7, then
// per sample the words named by flag bits 8-15.
// Output channel: one record per sample (result_kind_o = 0), or a single
// empty-run record (result_kind_o = 1) when the count or the per-sample word
// set is zero; last_of_run_o marks the final record of a box.
// A record is loaded into the result register when the word completing it
// steps on from the input register through the decode; the step waits while
// the result register holds a record not yet taken. Words that complete
// nothing give no record. Throughput: one word per cycle while the result
// register has room, set by the combinational decode and counter update.
// Reset: no box is open; words without box_start_i are dropped.
// When the receiver stalls, the result register holds its record, one more
// word waits in the input register, and in_ready_o falls after that.
module track_run_box_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] stream_word_i,
  input  logic        box_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [31:0] sample_index_o,
  output logic [31:0] sample_dur_o,
  output logic [31:0] sample_bytes_o,
  output logic [31:0] sample_flag_word_o,
  output logic [31:0] composition_offset_o,
  output logic [31:0] data_ofs_value_o,
  output logic [31:0] first_flags_value_o,
  output logic        last_of_run_o
);
  import trbp_pkg::*;

  in_item_t in_item;
  in_item_t held_item;
  logic     step;
  logic     out_free;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign in_item.stream_word = stream_word_i;
  assign in_item.box_start   = box_start_i;

  trbp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .out_free_i (out_free),
    .step_o     (step),
    .item_o     (held_item)
  );

  trbp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  trbp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign result_kind_o        = out_res.result_kind;
  assign sample_index_o       = out_res.sample_index;
  assign sample_dur_o         = out_res.sample_dur;
  assign sample_bytes_o       = out_res.sample_bytes;
  assign sample_flag_word_o   = out_res.sample_flag_word;
  assign composition_offset_o = out_res.composition_offset;
  assign data_ofs_value_o     = out_res.data_ofs_value;
  assign first_flags_value_o  = out_res.first_flags_value;
  assign last_of_run_o        = out_res.last_of_run;

endmodule

>>> src/trbp_in_reg.sv
`timescale 1ns / 1ps

module trbp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  trbp_pkg::in_item_t item_i,
  input  logic              out_free_i,
  output logic              step_o,
  output trbp_pkg::in_item_t item_o
);
  import trbp_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  // Move the held request on whenever the result side has room
  assign step_o     = valid_q && out_free_i;
  assign in_ready_o = !valid_q || out_free_i;
  assign take       = in_valid_i && in_ready_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (step_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload of an accepted request
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

endmodule

>>> src/trbp_parser.sv
`timescale 1ns / 1ps

module trbp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  trbp_pkg::in_item_t item_i,
  output logic               res_valid_o,
  output trbp_pkg::result_t  res_o
);
  import trbp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_COUNT  = 4'b0010,
    PH_HEADER = 4'b0100,
    PH_SAMPLE = 4'b1000
  } phase_e;

  function automatic logic [3:0] count8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'b000, v[i]};
    end
    return c;
  endfunction

  phase_e            phase_q, phase_d;
  logic [15:0]       flags_q, flags_d;
  logic [31:0]       total_q, total_d;
  logic [31:0]       counter_q, counter_d;
  logic [3:0]        hdr_left_q, hdr_left_d;
  logic [2:0]        pos_q, pos_d;
  logic [31:0]       data_off_q, data_off_d;
  logic [31:0]       first_flags_q, first_flags_d;
  logic [3:0][31:0]  fields_q, fields_d;

  logic [7:0]        hdr_bits;
  logic [7:0]        rec_bits;
  logic [3:0]        hdr_cnt;
  logic [3:0]        rec_cnt;
  logic [3:0]        hdr_idx;
  logic [3:0]        pos_inc;
  logic [3:0][1:0]   rank;
  logic [3:0][31:0]  fields_next;
  logic              finish;
  logic              last;
  logic [31:0]       word;

  assign word     = item_i.stream_word;
  assign hdr_bits = flags_q[7:0] & HdrMask[7:0];
  assign rec_bits = flags_q[15:8] & RecMask[15:8];
  assign hdr_cnt  = count8(hdr_bits);
  assign rec_cnt  = count8(rec_bits);
  assign hdr_idx  = hdr_cnt - hdr_left_q;
  assign pos_inc  = {1'b0, pos_q} + 4'd1;
  assign last     = (counter_q == total_q - 32'd1);

  // Word slot of each record field among the present fields
  assign rank[0] = 2'd0;
  assign rank[1] = {1'b0, rec_bits[0]};
  assign rank[2] = {1'b0, rec_bits[0]} + {1'b0, rec_bits[1]};
  assign rank[3] = {1'b0, rec_bits[0]} + {1'b0, rec_bits[1]} + {1'b0, rec_bits[2]};

  // Drop the word into the record field whose slot is current
  always_comb begin
    fields_next = fields_q;
    for (int b = 0; b < 4; b++) begin
      if (rec_bits[b] && ({1'b0, rank[b]} == pos_q)) begin
        fields_next[b] = word;
      end
    end
  end

  // Advance the parse state and form the result of one word
  always_comb begin
    phase_d       = phase_q;
    flags_d       = flags_q;
    total_d       = total_q;
    counter_d     = counter_q;
    hdr_left_d    = hdr_left_q;
    pos_d         = pos_q;
    data_off_d    = data_off_q;
    first_flags_d = first_flags_q;
    fields_d      = fields_q;
    finish        = 1'b0;
    res_valid_o   = 1'b0;
    res_o         = '0;

    if (step_i) begin
      if (item_i.box_start) begin
        flags_d = word[15:0];
        phase_d = PH_COUNT;
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
          end
          PH_COUNT: begin
            total_d       = word;
            data_off_d    = '0;
            first_flags_d = '0;
            hdr_left_d    = hdr_cnt;
            if (hdr_cnt == 4'd0) begin
              finish = 1'b1;
            end else begin
              phase_d = PH_HEADER;
            end
          end
          PH_HEADER: begin
            if (flags_q[0] && (hdr_idx == 4'd0)) begin
              data_off_d = word;
            end else if (flags_q[2] && (hdr_idx == {3'b000, flags_q[0]})) begin
              first_flags_d = word;
            end
            hdr_left_d = hdr_left_q - 4'd1;
            if (hdr_left_q == 4'd1) begin
              finish = 1'b1;
            end
          end
          PH_SAMPLE: begin
            if (pos_inc >= rec_cnt) begin
              res_valid_o                = 1'b1;
              res_o.result_kind          = KIND_SAMPLE;
              res_o.sample_index         = counter_q;
              res_o.sample_dur           = fields_next[0];
              res_o.sample_bytes         = fields_next[1];
              res_o.sample_flag_word     = fields_next[2];
              res_o.composition_offset   = fields_next[3];
              res_o.data_ofs_value       = data_off_q;
              res_o.first_flags_value    = first_flags_q;
              res_o.last_of_run          = last;
              counter_d = counter_q + 32'd1;
              pos_d     = '0;
              fields_d  = '0;
              if (last) begin
                phase_d = PH_IDLE;
              end
            end else begin
              pos_d    = pos_inc[2:0];
              fields_d = fields_next;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end

      // Header complete: report an empty run or open the sample phase
      if (finish) begin
        if ((total_d == 32'd0) || (rec_cnt == 4'd0)) begin
          res_valid_o             = 1'b1;
          res_o.result_kind       = KIND_EMPTY;
          res_o.data_ofs_value    = data_off_d;
          res_o.first_flags_value = first_flags_d;
          res_o.last_of_run       = 1'b1;
          phase_d                 = PH_IDLE;
        end else begin
          phase_d   = PH_SAMPLE;
          counter_d = '0;
          pos_d     = '0;
          fields_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      flags_q       <= '0;
      total_q       <= '0;
      counter_q     <= '0;
      hdr_left_q    <= '0;
      pos_q         <= '0;
      data_off_q    <= '0;
      first_flags_q <= '0;
      fields_q      <= '0;
    end else begin
      phase_q       <= phase_d;
      flags_q       <= flags_d;
      total_q       <= total_d;
      counter_q     <= counter_d;
      hdr_left_q    <= hdr_left_d;
      pos_q         <= pos_d;
      data_off_q    <= data_off_d;
      first_flags_q <= first_flags_d;
      fields_q      <= fields_d;
    end
  end

`ifndef ASSERT_OFF
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.result_kind == KIND_EMPTY)) |-> res_o.last_of_run)
    else $error("empty-run result without last marker");

  a_last_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_of_run) |=> (phase_q == PH_IDLE))
    else $error("parser not idle after last result");

  a_header_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEADER) |-> (hdr_left_q != 4'd0))
    else $error("header phase with no header words left");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SAMPLE) |-> ({1'b0, pos_q} < rec_cnt))
    else $error("record word position past record length");

  a_result_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> step_i)
    else $error("result without a word");
`endif

endmodule

>>> src/trbp_out_reg.sv
`timescale 1ns / 1ps

module trbp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              res_valid_i,
  input  trbp_pkg::result_t res_i,
  output logic              out_free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output trbp_pkg::result_t res_o
);
  import trbp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  // Room when empty or when the held result leaves this cycle
  assign out_free_o  = !valid_q || out_ready_i;
  assign load        = step_i && res_valid_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (out_free_o) begin
      valid_d = load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

endmodule

>>> test/track_run_box_parser_top_tb.sv
`timescale 1ns / 1ps

module track_run_box_parser_top_tb;
  import trbp_pkg::*;

  // Parser phases of the behavioral predictor
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_HEADER,
    ST_SAMPLE
  } parse_state_e;

  // One row of the directed table; rec is used only where known is set
  typedef struct {
    logic [31:0] word;
    logic        start;
    bit          known;
    result_t     rec;
  } box_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] stream_word_i = '0;
  logic        box_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        result_kind_o;
  logic [31:0] sample_index_o;
  logic [31:0] sample_dur_o;
  logic [31:0] sample_bytes_o;
  logic [31:0] sample_flag_word_o;
  logic [31:0] composition_offset_o;
  logic [31:0] data_ofs_value_o;
  logic [31:0] first_flags_value_o;
  logic        last_of_run_o;

  // Predictor state
  parse_state_e parse_state = ST_IDLE;
  logic [15:0]  run_flags = '0;
  logic [31:0]  run_count = '0;
  logic [31:0]  sample_num = '0;
  int unsigned  hdr_left = 0;
  int unsigned  word_pos = 0;
  logic [31:0]  data_ofs = '0;
  logic [31:0]  first_flags = '0;
  logic [31:0]  fields [4] = '{default: '0};

  result_t     pending_records [$];
  box_row_t    box_table [$];
  int unsigned error_count = 0;
  int unsigned words_taken = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  track_run_box_parser_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .stream_word_i       (stream_word_i),
    .box_start_i         (box_start_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .result_kind_o       (result_kind_o),
    .sample_index_o      (sample_index_o),
    .sample_dur_o        (sample_dur_o),
    .sample_bytes_o      (sample_bytes_o),
    .sample_flag_word_o  (sample_flag_word_o),
    .composition_offset_o(composition_offset_o),
    .data_ofs_value_o    (data_ofs_value_o),
    .first_flags_value_o (first_flags_value_o),
    .last_of_run_o       (last_of_run_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s: got %h, expected %h", name, got, want));
    end
  endtask

  // Build a record from the current predictor state
  function automatic result_t make_record(input kind_e kind, input logic last);
    result_t rec;
    rec = '0;
    rec.result_kind = kind;
    rec.data_ofs_value = data_ofs;
    rec.first_flags_value = first_flags;
    rec.last_of_run = last;
    if (kind == KIND_SAMPLE) begin
      rec.sample_index = sample_num;
      rec.sample_dur = fields[0];
      rec.sample_bytes = fields[1];
      rec.sample_flag_word = fields[2];
      rec.composition_offset = fields[3];
    end
    return rec;
  endfunction

  // Header complete: report an empty run or enter the sample phase
  task automatic close_header(output bit got, output result_t rec);
    got = 1'b0;
    rec = '0;
    if (run_count == 0 || (run_flags & RecMask) == '0) begin
      got = 1'b1;
      rec = make_record(KIND_EMPTY, 1'b1);
      parse_state = ST_IDLE;
    end else begin
      parse_state = ST_SAMPLE;
      sample_num = '0;
      word_pos = 0;
      fields = '{default: '0};
    end
  endtask

  // Advance the predicted parser by one accepted word
  task automatic parse_word(input logic [31:0] w, input logic s,
                            output bit got, output result_t rec);
    int unsigned idx;
    int unsigned seen;
    got = 1'b0;
    rec = '0;
    if (s) begin
      run_flags = w[15:0];
      parse_state = ST_COUNT;
    end else begin
      case (parse_state)
        ST_COUNT: begin
          run_count = w;
          data_ofs = '0;
          first_flags = '0;
          hdr_left = $countones(run_flags & HdrMask);
          if (hdr_left == 0) close_header(got, rec);
          else parse_state = ST_HEADER;
        end
        ST_HEADER: begin
          idx = $countones(run_flags & HdrMask) - hdr_left;
          if (run_flags[0] && idx == 0) data_ofs = w;
          else if (run_flags[2] && idx == (run_flags[0] ? 1 : 0)) first_flags = w;
          hdr_left--;
          if (hdr_left == 0) close_header(got, rec);
        end
        ST_SAMPLE: begin
          seen = 0;
          for (int b = 0; b < 4; b++) begin
            if (run_flags[8+b]) begin
              if (seen == word_pos) fields[b] = w;
              seen++;
            end
          end
          word_pos++;
          if (word_pos >= $countones(run_flags & RecMask)) begin
            got = 1'b1;
            rec = make_record(KIND_SAMPLE, sample_num == run_count - 1);
            if (rec.last_of_run) parse_state = ST_IDLE;
            sample_num++;
            word_pos = 0;
            fields = '{default: '0};
          end
        end
        default: ;
      endcase
    end
  endtask

  // Drive one request, wait for acceptance, then queue its expected record
  task automatic send_word(input logic [31:0] w, input logic s, input bit known,
                           input result_t known_rec);
    bit      got;
    result_t rec;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_word_i <= w;
    box_start_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    if (s || parse_state != ST_IDLE) words_taken++;
    parse_word(w, s, got, rec);
    if (known) pending_records.push_back(known_rec);
    else if (got) pending_records.push_back(rec);
  endtask

  // One box with random flags and content; some are cut short or preceded by noise
  task automatic send_random_box();
    logic [15:0] flags;
    logic [31:0] count;
    longint      total;
    int unsigned pick;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0, 1'b0, '0);
    end
    flags = 16'($urandom);
    pick = $urandom_range(3);
    if (pick == 0) flags[7:0] = '0;
    else if (pick == 1) flags[7:0] = flags[7:0] & 8'h05;
    pick = $urandom_range(9);
    if (pick == 0) flags[15:8] = '0;
    else if (pick < 5) flags[15:12] = '0;
    pick = $urandom_range(19);
    if (pick == 0) count = '0;
    else if (pick == 1) count = $urandom;
    else if (pick == 2) count = '1;
    else count = $urandom_range(1, 4);
    total = 2 + $countones(flags[7:0]) + longint'(count) * $countones(flags[15:8]);
    if (total > 40) total = 40;
    if ($urandom_range(9) == 0) total = $urandom_range(1, int'(total) - 1);
    send_word({16'($urandom), flags}, 1'b1, 1'b0, '0);
    if (total > 1) send_word(count, 1'b0, 1'b0, '0);
    for (longint i = 2; i < total; i++) send_word($urandom, 1'b0, 1'b0, '0);
  endtask

  function automatic box_row_t row(input logic [31:0] word, input logic start);
    box_row_t r;
    r.word = word;
    r.start = start;
    r.known = 1'b0;
    r.rec = '0;
    return r;
  endfunction

  function automatic box_row_t row_rec(input logic [31:0] word, input result_t rec);
    box_row_t r;
    r = row(word, 1'b0);
    r.known = 1'b1;
    r.rec = rec;
    return r;
  endfunction

  // Check each record taken by the receiver and randomize its stalls
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_records.size() == 0) begin
        report_error($sformatf("record with nothing pending, sample_index %h",
                               sample_index_o));
      end else begin
        want = pending_records.pop_front();
        check_field("result_kind", result_kind_o, want.result_kind);
        check_field("sample_index", sample_index_o, want.sample_index);
        check_field("sample_dur", sample_dur_o, want.sample_dur);
        check_field("sample_bytes", sample_bytes_o, want.sample_bytes);
        check_field("sample_flag_word", sample_flag_word_o, want.sample_flag_word);
        check_field("composition_offset", composition_offset_o, want.composition_offset);
        check_field("data_ofs_value", data_ofs_value_o, want.data_ofs_value);
        check_field("first_flags_value", first_flags_value_o, want.first_flags_value);
        check_field("last_of_run", last_of_run_o, want.last_of_run);
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    int unsigned idle_set [4] = '{0, 67, 0, 34};
    int unsigned stall_set [4] = '{0, 0, 67, 34};
    int unsigned target;

    // Word while idle, then an empty box with no flags
    box_table.push_back(row(32'h0000_1234, 1'b0));
    box_table.push_back(row(32'h0000_0000, 1'b1));
    box_table.push_back(row_rec(32'd5, '{KIND_EMPTY, '0, '0, '0, '0, '0, '0, '0, 1'b1}));
    // Full box: version bits set, both header words, all four sample words
    box_table.push_back(row(32'hFFFF_0F05, 1'b1));
    box_table.push_back(row(32'd1, 1'b0));
    box_table.push_back(row(32'hFFFF_FFFF, 1'b0));
    box_table.push_back(row(32'h8000_0001, 1'b0));
    box_table.push_back(row(32'hFFFF_FFFF, 1'b0));
    box_table.push_back(row(32'h0000_0000, 1'b0));
    box_table.push_back(row(32'hAAAA_AAAA, 1'b0));
    box_table.push_back(row_rec(32'h5555_5555,
        '{KIND_SAMPLE, '0, 32'hFFFF_FFFF, '0, 32'hAAAA_AAAA, 32'h5555_5555,
          32'hFFFF_FFFF, 32'h8000_0001, 1'b1}));
    // Restart inside a box, then a skipped header word and no sample words
    box_table.push_back(row(32'h0000_0100, 1'b1));
    box_table.push_back(row(32'd3, 1'b0));
    box_table.push_back(row(32'd7, 1'b0));
    box_table.push_back(row(32'h0000_0006, 1'b1));
    box_table.push_back(row(32'hFFFF_FFFF, 1'b0));
    box_table.push_back(row(32'h0000_0011, 1'b0));
    box_table.push_back(row_rec(32'h0000_0022,
        '{KIND_EMPTY, '0, '0, '0, '0, '0, '0, 32'h11, 1'b1}));
    // Word after the run, then zero sample count with only skipped sample bits
    box_table.push_back(row(32'h0000_0033, 1'b0));
    box_table.push_back(row(32'h0000_F000, 1'b1));
    box_table.push_back(row_rec(32'd0, '{KIND_EMPTY, '0, '0, '0, '0, '0, '0, '0, 1'b1}));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (box_table[i]) begin
      send_word(box_table[i].word, box_table[i].start, box_table[i].known,
                box_table[i].rec);
    end

    // Random boxes under each idle and stall mix
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      target = words_taken + 100;
      while (words_taken < target) send_random_box();
    end
    in_valid_i <= 1'b0;

    // Drain, then give a stray record time to show up
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
